>>> hw/rtl/blr_pkg.sv
package blr_pkg;

  localparam int COORD_BITS   = 16;
  localparam int SCALE_BITS   = 8;
  localparam int COLOR_BITS   = 16;
  localparam int SPAN_BITS    = COORD_BITS + 1;
  localparam int DEC_BITS     = COORD_BITS + 4;
  localparam int CNT_BITS     = $clog2(COORD_BITS);
  localparam int CFG_IDX_BITS = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        ucoord_t;
  typedef logic [SCALE_BITS-1:0]        scale_t;
  typedef logic [COLOR_BITS-1:0]        color_t;
  typedef logic [CFG_IDX_BITS-1:0]      cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t REG_ORIGIN_X = 2'd0;
  localparam cfg_idx_t REG_ORIGIN_Y = 2'd1;

  // request types
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

endpackage

>>> hw/rtl/blr_div.sv
module blr_div
  import blr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   go,
  input  coord_t dividend,
  input  scale_t divisor,
  output logic   done,
  output coord_t quotient
);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [SCALE_BITS-1:0] rem;
  ucoord_t             quo;
  logic                neg;
  scale_t              dvs;
  logic [SCALE_BITS:0] rem_sh;
  logic [SCALE_BITS:0] rem_sub;
  logic                fits;

  // restoring division, one quotient bit per cycle on the magnitude
  always_comb begin
    rem_sh  = {rem, quo[COORD_BITS-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    fits    = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(COORD_BITS - 1);
        rem  <= '0;
        quo  <= dividend[COORD_BITS-1] ? ucoord_t'(-dividend) : ucoord_t'(dividend);
        neg  <= dividend[COORD_BITS-1];
        dvs  <= divisor;
      end else if (busy) begin
        rem <= fits ? rem_sub[SCALE_BITS-1:0] : rem_sh[SCALE_BITS-1:0];
        quo <= {quo[COORD_BITS-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // truncation toward zero: negate the magnitude quotient
  assign quotient = neg ? -coord_t'(quo) : coord_t'(quo);

endmodule

>>> hw/rtl/blr_pix.sv
module blr_pix
  import blr_pkg::*;
(
  input  ucoord_t pos,
  input  scale_t  scale,
  input  ucoord_t origin,
  output ucoord_t screen
);

  logic [COORD_BITS+SCALE_BITS-1:0] prod;

  // scale back to block corner, then shift into the window, modulo 2^COORD_BITS
  assign prod   = pos * scale;
  assign screen = prod[COORD_BITS-1:0] + origin;

endmodule

>>> hw/rtl/block_line_rasterizer_core.sv
// Pull-driven Bresenham line rasterizer. A load request (req_type 0) sets up a line and
// gives no result; each step request (req_type 1) gives the next pixel or block corner,
// with the window origin added, and last marks the final one (the end point itself is not
// drawn); a step with no line active gives nothing. A step waits in the emit state until
// the output register can take its result. A plain load goes through the setup state. In block
// mode (thickness above 1, plain_mode 0) the four endpoint coordinates first go one after
// another through a single shared bit-serial divider. in_ready is low while a request
// is being worked on; cfg_ready is always high, and origin writes apply to later steps.
module block_line_rasterizer_core
  import blr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     req_type,
  input  coord_t   x_start,
  input  coord_t   y_start,
  input  coord_t   x_end,
  input  coord_t   y_end,
  input  scale_t   thickness,
  input  color_t   color,
  input  logic     plain_mode,
  output logic     out_valid,
  input  logic     out_ready,
  output ucoord_t  pixel_x,
  output ucoord_t  pixel_y,
  output scale_t   block_size,
  output color_t   pixel_color,
  output logic     last,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  ucoord_t  cfg_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_SETUP = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  localparam logic [1:0] C_MA = 2'd0;
  localparam logic [1:0] C_MI = 2'd1;
  localparam logic [1:0] C_MB = 2'd2;
  localparam logic [1:0] C_NB = 2'd3;

  logic [1:0] state;
  logic [1:0] op;
  logic       div_go;
  logic       div_done;
  coord_t     div_q;

  ucoord_t origin_x;
  ucoord_t origin_y;

  coord_t crd [4];

  logic                  line_active;
  logic                  steep_flag;
  logic                  block_flag;
  coord_t                major_pos;
  coord_t                major_stop;
  coord_t                minor_pos;
  logic                  minor_down;
  logic signed [DEC_BITS-1:0] decision;
  logic [SPAN_BITS-1:0]  major_span;
  logic [SPAN_BITS-1:0]  minor_span;
  scale_t                block_scale;
  color_t                held_color;

  // load decode
  logic signed [SPAN_BITS-1:0] dx;
  logic signed [SPAN_BITS-1:0] dy;
  logic [SPAN_BITS-1:0]        adx;
  logic [SPAN_BITS-1:0]        ady;
  logic                        steep_in;
  coord_t                      ma_raw;
  coord_t                      mi_raw;
  coord_t                      mb_raw;
  coord_t                      nb_raw;
  logic                        swap;
  logic                        block_in;

  // setup
  logic signed [SPAN_BITS-1:0] maj_diff;
  logic signed [SPAN_BITS-1:0] min_diff;
  logic [SPAN_BITS-1:0]        min_abs;
  logic signed [DEC_BITS-1:0]  dec_init;

  // step
  logic                       dec_pos;
  logic signed [DEC_BITS-1:0] two_maj;
  logic signed [DEC_BITS-1:0] two_min;
  logic signed [DEC_BITS-1:0] decision_next;
  coord_t                     major_pos_next;
  coord_t                     minor_pos_next;
  logic                       is_last;
  ucoord_t                    px;
  ucoord_t                    py;
  ucoord_t                    sx;
  ucoord_t                    sy;
  logic                       emit_ok;
  logic                       in_fire;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign emit_ok   = !out_valid || out_ready;

  always_comb begin
    dx       = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
    dy       = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
    adx      = dx[SPAN_BITS-1] ? SPAN_BITS'(-dx) : SPAN_BITS'(dx);
    ady      = dy[SPAN_BITS-1] ? SPAN_BITS'(-dy) : SPAN_BITS'(dy);
    steep_in = !(ady < adx);
    ma_raw   = steep_in ? y_start : x_start;
    mi_raw   = steep_in ? x_start : y_start;
    mb_raw   = steep_in ? y_end   : x_end;
    nb_raw   = steep_in ? x_end   : y_end;
    swap     = (ma_raw > mb_raw);
    block_in = (thickness > scale_t'(1)) && !plain_mode;
  end

  always_comb begin
    maj_diff = {crd[C_MB][COORD_BITS-1], crd[C_MB]} - {crd[C_MA][COORD_BITS-1], crd[C_MA]};
    min_diff = {crd[C_NB][COORD_BITS-1], crd[C_NB]} - {crd[C_MI][COORD_BITS-1], crd[C_MI]};
    min_abs  = min_diff[SPAN_BITS-1] ? SPAN_BITS'(-min_diff) : SPAN_BITS'(min_diff);
    dec_init = DEC_BITS'({min_abs, 1'b0}) - DEC_BITS'(maj_diff);
  end

  always_comb begin
    dec_pos        = !decision[DEC_BITS-1] && (decision != '0);
    two_maj        = DEC_BITS'({major_span, 1'b0});
    two_min        = DEC_BITS'({minor_span, 1'b0});
    decision_next  = decision - (dec_pos ? two_maj : '0) + two_min;
    major_pos_next = major_pos + 1'b1;
    minor_pos_next = dec_pos ? (minor_down ? minor_pos - 1'b1 : minor_pos + 1'b1) : minor_pos;
    is_last        = (major_pos_next == major_stop);
    px             = steep_flag ? ucoord_t'(minor_pos) : ucoord_t'(major_pos);
    py             = steep_flag ? ucoord_t'(major_pos) : ucoord_t'(minor_pos);
  end

  blr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (crd[op]),
    .divisor  (block_scale),
    .done     (div_done),
    .quotient (div_q)
  );

  blr_pix u_pix_x (
    .pos    (px),
    .scale  (block_scale),
    .origin (origin_x),
    .screen (sx)
  );

  blr_pix u_pix_y (
    .pos    (py),
    .scale  (block_scale),
    .origin (origin_y),
    .screen (sy)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and line state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op          <= C_MA;
      div_go      <= 1'b0;
      out_valid   <= 1'b0;
      line_active <= 1'b0;
      steep_flag  <= 1'b0;
      block_flag  <= 1'b0;
      block_scale <= scale_t'(1);
      held_color  <= '0;
    end else begin
      div_go <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (req_type == REQ_LOAD) begin
              crd[C_MA]   <= swap ? mb_raw : ma_raw;
              crd[C_MI]   <= swap ? nb_raw : mi_raw;
              crd[C_MB]   <= swap ? ma_raw : mb_raw;
              crd[C_NB]   <= swap ? mi_raw : nb_raw;
              steep_flag  <= steep_in;
              block_flag  <= block_in;
              block_scale <= block_in ? thickness : scale_t'(1);
              held_color  <= color;
              op          <= C_MA;
              if (block_in) begin
                div_go <= 1'b1;
                state  <= S_DIV;
              end else begin
                state <= S_SETUP;
              end
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            crd[op] <= div_q;
            if (op == C_NB) begin
              state <= S_SETUP;
            end else begin
              op     <= op + 1'b1;
              div_go <= 1'b1;
            end
          end
        end
        S_SETUP: begin
          major_span  <= SPAN_BITS'(maj_diff);
          minor_span  <= min_abs;
          minor_down  <= min_diff[SPAN_BITS-1];
          decision    <= dec_init;
          major_pos   <= crd[C_MA];
          minor_pos   <= crd[C_MI];
          major_stop  <= crd[C_MB];
          line_active <= (crd[C_MA] < crd[C_MB]);
          state       <= S_IDLE;
        end
        S_EMIT: begin
          if (!line_active) begin
            state <= S_IDLE;
          end else if (emit_ok) begin
            out_valid   <= 1'b1;
            pixel_x     <= sx;
            pixel_y     <= sy;
            block_size  <= block_scale;
            pixel_color <= held_color;
            last        <= is_last;
            decision    <= decision_next;
            minor_pos   <= minor_pos_next;
            major_pos   <= major_pos_next;
            line_active <= !is_last;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/blr_checker.sv
module blr_checker
  import blr_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input ucoord_t pixel_x,
  input ucoord_t pixel_y,
  input scale_t  block_size,
  input logic    last
);

  // every request keeps the block busy in the cycle after it is taken
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after a request was taken");

  // a new result only appears after a step has been worked on
  a_result_after_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a step in progress");

  // block side is never zero
  a_block_size_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> block_size != '0)
    else $error("zero block size on a result");

  // stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(last))
    else $error("stalled result changed");

endmodule

bind block_line_rasterizer_core blr_checker u_blr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .pixel_x    (pixel_x),
  .pixel_y    (pixel_y),
  .block_size (block_size),
  .last       (last)
);

>>> sim/tb_block_line_rasterizer_core.sv
`timescale 1ns / 100ps

module tb_block_line_rasterizer_core
  import blr_pkg::*;
();

  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE_CYCLS = 120;
  localparam int RAND_ITEMS   = 700;
  localparam int MAX_STEPS    = 40;

  typedef struct packed {
    logic   kind;
    coord_t xs;
    coord_t ys;
    coord_t xe;
    coord_t ye;
    scale_t thick;
    color_t col;
    logic   plain;
  } line_req_t;

  typedef struct packed {
    ucoord_t px;
    ucoord_t py;
    scale_t  size;
    color_t  col;
    logic    last_px;
  } pix_t;

  typedef enum logic [1:0] {BY_MODEL, EXPECT_NONE, EXPECT_PIXEL} chk_t;

  typedef struct {
    line_req_t req;
    chk_t      chk;
    pix_t      want;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  logic     req_type;
  coord_t   x_start;
  coord_t   y_start;
  coord_t   x_end;
  coord_t   y_end;
  scale_t   thickness;
  color_t   color;
  logic     plain_mode;
  logic     out_valid;
  logic     out_ready;
  ucoord_t  pixel_x;
  ucoord_t  pixel_y;
  scale_t   block_size;
  color_t   pixel_color;
  logic     last;
  logic     cfg_valid;
  logic     cfg_ready;
  cfg_idx_t cfg_index;
  ucoord_t  cfg_data;

  block_line_rasterizer_core uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .x_start     (x_start),
    .y_start     (y_start),
    .x_end       (x_end),
    .y_end       (y_end),
    .thickness   (thickness),
    .color       (color),
    .plain_mode  (plain_mode),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .block_size  (block_size),
    .pixel_color (pixel_color),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // line tracker state
  bit      trk_active;
  bit      trk_steep;
  bit      trk_block;
  bit      trk_down;
  longint  trk_major;
  longint  trk_major_end;
  longint  trk_minor;
  longint  trk_err;
  longint  trk_major_len;
  longint  trk_minor_len;
  scale_t  trk_scale;
  color_t  trk_color;
  ucoord_t org_x;
  ucoord_t org_y;

  pix_t     pending_pixels[$];
  dir_row_t dir_rows[$];
  pix_t     head_pix;

  int  n_errors;
  int  n_sent;
  int  n_pixels;
  int  n_loads;
  int  n_block_loads;
  int  n_origins;
  int  stall_cycles;
  int  hold_cycles;
  bit  tx_steady;
  bit  rx_steady;

  function automatic void line_reset();
    trk_active    = 1'b0;
    trk_steep     = 1'b0;
    trk_block     = 1'b0;
    trk_down      = 1'b0;
    trk_major     = 0;
    trk_major_end = 0;
    trk_minor     = 0;
    trk_err       = 0;
    trk_major_len = 0;
    trk_minor_len = 0;
    trk_scale     = 8'd1;
    trk_color     = '0;
    org_x         = '0;
    org_y         = '0;
  endfunction

  function automatic void line_setup(line_req_t r);
    longint xa, ya, xb, yb, adx, ady, ma, mi, mb, nb, t, d, s;
    xa  = longint'($signed(r.xs));
    ya  = longint'($signed(r.ys));
    xb  = longint'($signed(r.xe));
    yb  = longint'($signed(r.ye));
    adx = (xb > xa) ? xb - xa : xa - xb;
    ady = (yb > ya) ? yb - ya : ya - yb;
    trk_steep = !(ady < adx);
    if (trk_steep) begin
      ma = ya; mi = xa; mb = yb; nb = xb;
    end else begin
      ma = xa; mi = ya; mb = xb; nb = yb;
    end
    // walk the major axis upward
    if (ma > mb) begin
      t = ma; ma = mb; mb = t;
      t = mi; mi = nb; nb = t;
    end
    trk_block = (r.thick > 8'd1) && !r.plain;
    trk_scale = trk_block ? r.thick : 8'd1;
    trk_color = r.col;
    if (trk_block) begin
      s  = longint'(r.thick);
      ma = ma / s;
      mi = mi / s;
      mb = mb / s;
      nb = nb / s;
    end
    trk_major_len = mb - ma;
    d             = nb - mi;
    trk_down      = d < 0;
    trk_minor_len = trk_down ? -d : d;
    trk_err       = 2 * trk_minor_len - trk_major_len;
    trk_major     = ma;
    trk_minor     = mi;
    trk_major_end = mb;
    trk_active    = ma < mb;
  endfunction

  function automatic ucoord_t to_screen(longint pos, ucoord_t org);
    longint v;
    v = trk_block ? pos * longint'(trk_scale) : pos;
    return ucoord_t'(v + longint'(org));
  endfunction

  function automatic bit line_step(output pix_t p);
    longint sx, sy;
    p = '0;
    if (!trk_active)
      return 1'b0;
    sx = trk_steep ? trk_minor : trk_major;
    sy = trk_steep ? trk_major : trk_minor;
    p.px      = to_screen(sx, org_x);
    p.py      = to_screen(sy, org_y);
    p.size    = trk_scale;
    p.col     = trk_color;
    p.last_px = (trk_major + 1 == trk_major_end);
    if (trk_err > 0) begin
      trk_minor += trk_down ? longint'(-1) : longint'(1);
      trk_err   -= 2 * trk_major_len;
    end
    trk_err += 2 * trk_minor_len;
    trk_major++;
    if (trk_major >= trk_major_end)
      trk_active = 1'b0;
    return 1'b1;
  endfunction

  function automatic pix_t pix(ucoord_t x, ucoord_t y, scale_t s, color_t c, logic l);
    pix_t p;
    p.px      = x;
    p.py      = y;
    p.size    = s;
    p.col     = c;
    p.last_px = l;
    return p;
  endfunction

  function automatic line_req_t rand_req(logic kind);
    line_req_t r;
    r.kind  = kind;
    r.xs    = coord_t'($urandom);
    r.ys    = coord_t'($urandom);
    r.xe    = coord_t'($urandom);
    r.ye    = coord_t'($urandom);
    r.thick = scale_t'($urandom);
    r.col   = color_t'($urandom);
    r.plain = 1'($urandom);
    return r;
  endfunction

  function automatic line_req_t make_line();
    line_req_t r;
    int pick, dx, dy;
    r = rand_req(REQ_LOAD);
    case ($urandom_range(4))
      0, 1:    r.thick = scale_t'($urandom_range(1));
      2, 3:    r.thick = scale_t'($urandom_range(12, 2));
      default: r.thick = scale_t'($urandom_range(255, 2));
    endcase
    r.plain = ($urandom_range(3) == 0);
    pick = $urandom_range(99);
    if (pick < 70) begin
      // short line near a random spot
      dx = $urandom_range(60) - 30;
      dy = $urandom_range(60) - 30;
      if (r.thick > 8'd1 && !r.plain) begin
        dx = dx * int'(r.thick);
        dy = dy * int'(r.thick);
      end
      r.xe = r.xs + coord_t'(dx);
      r.ye = r.ys + coord_t'(dy);
    end else if (pick < 80) begin
      r.xe = r.xs;
      r.ye = r.ys;
    end
    return r;
  endfunction

  function automatic void add_load(int xs, int ys, int xe, int ye,
                                   scale_t th, color_t c, logic pl);
    dir_row_t row;
    row.req       = rand_req(REQ_LOAD);
    row.req.xs    = coord_t'(xs);
    row.req.ys    = coord_t'(ys);
    row.req.xe    = coord_t'(xe);
    row.req.ye    = coord_t'(ye);
    row.req.thick = th;
    row.req.col   = c;
    row.req.plain = pl;
    row.chk       = EXPECT_NONE;
    row.want      = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_step(chk_t chk, pix_t want);
    dir_row_t row;
    row.req  = rand_req(REQ_STEP);
    row.chk  = chk;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  task automatic report_miss(string what);
    $display("ERROR @%0t: %s", $time, what);
    n_errors++;
  endtask

  task automatic send(line_req_t r, chk_t chk, pix_t want);
    pix_t got;
    bit   has;
    bit   was_busy;
    if (!tx_steady)
      while ($urandom_range(99) < 27) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid   <= 1'b1;
    req_type   <= r.kind;
    x_start    <= r.xs;
    y_start    <= r.ys;
    x_end      <= r.xe;
    y_end      <= r.ye;
    thickness  <= r.thick;
    color      <= r.col;
    plain_mode <= r.plain;
    do @(negedge clk); while (!in_ready);
    was_busy = trk_active;
    has      = 1'b0;
    if (r.kind == REQ_LOAD) begin
      line_setup(r);
      n_loads++;
      if (trk_block)
        n_block_loads++;
    end else begin
      has = line_step(got);
    end
    if (chk == EXPECT_PIXEL)
      pending_pixels.push_back(want);
    else if (chk == BY_MODEL && has)
      pending_pixels.push_back(got);
    if (r.kind == REQ_LOAD || was_busy)
      n_sent++;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  task automatic set_origin(ucoord_t ox, ucoord_t oy);
    wait_drained();
    // a block-mode load may still be dividing
    repeat (SETTLE_CYCLS) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ORIGIN_X;
    cfg_data  <= ox;
    do @(negedge clk); while (!cfg_ready);
    org_x = ox;
    @(posedge clk);
    cfg_index <= REG_ORIGIN_Y;
    cfg_data  <= oy;
    do @(negedge clk); while (!cfg_ready);
    org_y = oy;
    @(posedge clk);
    cfg_valid <= 1'b0;
    n_origins++;
  endtask

  // receiver side
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else if (rx_steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 27);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_miss($sformatf("pixel %h,%h with no request pending", pixel_x, pixel_y));
      end else begin
        head_pix = pending_pixels.pop_front();
        n_pixels++;
        if (pixel_x !== head_pix.px)
          report_miss($sformatf("pixel_x %h, want %h", pixel_x, head_pix.px));
        if (pixel_y !== head_pix.py)
          report_miss($sformatf("pixel_y %h, want %h", pixel_y, head_pix.py));
        if (block_size !== head_pix.size)
          report_miss($sformatf("block_size %0d, want %0d", block_size, head_pix.size));
        if (pixel_color !== head_pix.col)
          report_miss($sformatf("pixel_color %h, want %h", pixel_color, head_pix.col));
        if (last !== head_pix.last_px)
          report_miss($sformatf("last %b, want %b", last, head_pix.last_px));
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stim
    line_req_t r;
    pix_t      none;
    int        span;
    int        nsteps;
    int        phase;
    int        next_phase;
    none        = '0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    req_type    = REQ_LOAD;
    x_start     = '0;
    y_start     = '0;
    x_end       = '0;
    y_end       = '0;
    thickness   = '0;
    color       = '0;
    plain_mode  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_ORIGIN_X;
    cfg_data    = '0;
    hold_cycles = 0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    line_reset();

    // step while idle, a short line run to its end, an empty line
    add_step(EXPECT_NONE, none);
    add_load(0, 0, 2, 0, 8'd0, 16'hABCD, 1'b0);
    add_step(EXPECT_PIXEL, pix(16'h0000, 16'h0000, 8'd1, 16'hABCD, 1'b0));
    add_step(EXPECT_PIXEL, pix(16'h0001, 16'h0000, 8'd1, 16'hABCD, 1'b1));
    add_step(EXPECT_NONE, none);
    add_load(5, 5, 5, 5, 8'd1, 16'h1111, 1'b0);
    add_step(EXPECT_NONE, none);
    // full-range diagonal, plain overrides thickness
    add_load(-32768, 32767, 32767, -32768, 8'd255, 16'hFFFF, 1'b1);
    add_step(EXPECT_PIXEL, pix(16'h7FFF, 16'h8000, 8'd1, 16'hFFFF, 1'b0));
    add_step(BY_MODEL, none);
    // block mode, 4x4 blocks
    add_load(0, 0, 10, 3, 8'd4, 16'h0F0F, 1'b0);
    add_step(EXPECT_PIXEL, pix(16'h0000, 16'h0000, 8'd4, 16'h0F0F, 1'b0));
    add_step(EXPECT_PIXEL, pix(16'h0004, 16'h0000, 8'd4, 16'h0F0F, 1'b1));
    add_step(EXPECT_NONE, none);
    add_load(-32768, -100, 32767, 200, 8'd255, 16'h1234, 1'b0);
    add_step(BY_MODEL, none);
    add_step(BY_MODEL, none);
    // load replaces a line in progress, steep and going down
    add_load(3, 10, 1, -5, 8'd2, 16'h5555, 1'b1);
    add_step(BY_MODEL, none);
    add_step(BY_MODEL, none);
    add_step(BY_MODEL, none);
    add_load(-7, -7, 8, -1, 8'd3, 16'h0000, 1'b0);
    add_step(BY_MODEL, none);
    add_step(BY_MODEL, none);
    add_step(BY_MODEL, none);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].want);

    phase      = 0;
    n_sent     = 0;
    next_phase = 0;
    while (n_sent < RAND_ITEMS) begin
      if (n_sent >= next_phase) begin
        next_phase += 110;
        phase++;
        case (phase)
          1:       set_origin(16'hFFFF, 16'hFFFF);
          2:       set_origin(ucoord_t'($urandom), ucoord_t'($urandom));
          3:       set_origin(16'h8000, 16'h7FFF);
          4:       set_origin(16'h0000, 16'hFFFF);
          5:       set_origin(16'hFFFF, 16'h0000);
          default: set_origin(ucoord_t'($urandom), ucoord_t'($urandom));
        endcase
        tx_steady = (phase == 2);
        rx_steady = (phase == 2);
        if (phase == 3) begin
          // receiver holds off while a long line keeps the requests coming
          hold_cycles = 300;
          r       = rand_req(REQ_LOAD);
          r.xe    = r.xs + coord_t'(100);
          r.ye    = r.ys + coord_t'(37);
          r.thick = 8'd1;
          send(r, BY_MODEL, none);
          repeat (60) send(rand_req(REQ_STEP), BY_MODEL, none);
          wait_drained();
        end
      end
      r = make_line();
      send(r, BY_MODEL, none);
      span = trk_active ? int'(trk_major_end - trk_major) : 0;
      case ($urandom_range(9))
        0:       nsteps = $urandom_range(3);
        1, 2:    nsteps = (span > 0) ? $urandom_range(span - 1) : 0;
        default: nsteps = span + $urandom_range(2);
      endcase
      if (nsteps > MAX_STEPS)
        nsteps = MAX_STEPS;
      repeat (nsteps) send(rand_req(REQ_STEP), BY_MODEL, none);
    end

    wait_drained();
    repeat (SETTLE_CYCLS) @(posedge clk);
    $display("covered %0d line loads (%0d in block mode), %0d pixels checked",
             n_loads, n_block_loads, n_pixels);
    $display("across %0d origin settings, with steady, stalled and random handshakes",
             n_origins + 1);
    if (n_errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/blr_pkg.sv
hw/rtl/blr_div.sv
hw/rtl/blr_pix.sv
hw/rtl/block_line_rasterizer_core.sv
hw/rtl/blr_checker.sv
sim/tb_block_line_rasterizer_core.sv
